// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: capacity, status codes, item types.
// No dependencies; used by every file of the block.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QCNT_W   = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] data_in;
    logic signed [15:0] priority_in;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [31:0]       out_data;
    logic signed [15:0]       out_priority;
    logic        [QCNT_W-1:0] queue_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with a new one,
// and shifts toward its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,
  input  wire entry_t    new_entry,
  input  wire logic      left_keep,
  input  wire entry_t    left_entry,
  input  wire entry_t    right_entry,
  output entry_t         entry_r,
  output logic           keep
);

  entry_t entry_nxt;

  // stay in place when held and not behind the new priority
  assign keep = occ && (entry_r.prio <= new_entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rem) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && !keep) begin
      entry_nxt = left_keep ? new_entry : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue: a chain of CAPACITY cells kept in priority order.
// The result strobes in the cycle after start is taken.
// Throughput 1 item per cycle; every cell compares and shifts in parallel,
// so busy stays low and the receiver cannot stall.
// Synchronous active-low reset empties the queue (count to zero) and
// clears the result strobe; cell contents are not reset.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_strobe,
  output out_item_t     out_item
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             strobe_r, strobe_nxt;
  out_item_t        result_r, result_nxt;

  cell_ctl_t            ctl;
  entry_t               new_entry;
  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_keep;
  logic                 accept, full, empty;
  logic [CNT_W+QCNT_W-1:0] count_ext;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign ctl.ins   = accept && (in_item.mode == MODE_INSERT) && !full;
  assign ctl.rem   = accept && (in_item.mode == MODE_REMOVE) && !empty;
  assign new_entry = '{data: in_item.data_in, prio: in_item.priority_in};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   lkeep;
    entry_t lent;
    entry_t rent;

    assign occ = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lent  = new_entry;
    end else begin : g_mid
      assign lkeep = cell_keep[i-1];
      assign lent  = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rent = '0;
    end else begin : g_body
      assign rent = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ),
      .new_entry   (new_entry),
      .left_keep   (lkeep),
      .left_entry  (lent),
      .right_entry (rent),
      .entry_r     (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = {{QCNT_W{1'b0}}, count_nxt};

  always_comb begin
    strobe_nxt              = accept;
    result_nxt.status       = ST_DONE;
    result_nxt.out_data     = '0;
    result_nxt.out_priority = '0;
    result_nxt.queue_count  = count_ext[QCNT_W-1:0];
    if (in_item.mode == MODE_INSERT) begin
      if (full) begin
        result_nxt.status = ST_FULL;
      end
    end else if (empty) begin
      result_nxt.status = ST_EMPTY;
    end else begin
      // head leaves from cell zero
      result_nxt.out_data     = cell_entry[0].data;
      result_nxt.out_priority = cell_entry[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = result_r;

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top.
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);

  localparam logic [CNT_W+QCNT_W-1:0] CAP_EXT = (CNT_W + QCNT_W)'(CAPACITY);

  // every taken item answers in the next cycle
  a_item_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("taken item gave no result");

  a_no_spurious: assert property (@(posedge clk)
    !(rst_n && start && !busy) |=> !out_strobe)
    else $error("result without a taken item");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ST_EMPTY) |->
      (out_item.queue_count == '0 && out_item.out_data == '0 &&
       out_item.out_priority == '0))
    else $error("empty remove reported wrong fields");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ST_FULL) |->
      (out_item.queue_count == CAP_EXT[QCNT_W-1:0] && out_item.out_data == '0))
    else $error("full insert reported wrong fields");

  a_remove_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == MODE_REMOVE) |=> (out_item.status != ST_FULL))
    else $error("remove flagged as full");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== test/spq_order_checker.sv =====
// Checker for the sorted priority queue: keeps its own sorted copy of the queue,
// predicts the result of every accepted item and compares it field by field.
// Depends on spq_pkg; instantiated next to the block by the testbench top.
module spq_order_checker
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_strobe,
  input  wire out_item_t out_item,
  output int             replies_owed,
  output int             fail_count
);

  logic signed [31:0] held_data [CAPACITY];
  logic signed [15:0] held_prio [CAPACITY];
  int                 held_count = 0;
  out_item_t          replies_due [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("spq mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one operation to the shadow queue and return the result it owes.
  function automatic out_item_t serve_queue_op(input in_item_t op);
    out_item_t res;
    int        pos;
    int        i;
    res = '0;
    res.status = ST_DONE;
    if (op.mode == MODE_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // go behind every entry of equal priority
        pos = 0;
        while (pos < held_count && held_prio[pos] <= op.priority_in) pos++;
        for (i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = op.data_in;
        held_prio[pos] = op.priority_in;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_data     = held_data[0];
        res.out_priority = held_prio[0];
        for (i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.queue_count = QCNT_W'(held_count);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_count = 0;
      replies_due.delete();
    end else begin
      // retire the oldest expectation before queuing the item taken at this edge
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with nothing pending, status",
                          32'(out_item.status), '0);
        end else begin
          want = replies_due.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.out_data !== want.out_data)
            report_mismatch("out_data", out_item.out_data, want.out_data);
          if (out_item.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(out_item.out_priority),
                            32'(want.out_priority));
          if (out_item.queue_count !== want.queue_count)
            report_mismatch("queue_count", 32'(out_item.queue_count),
                            32'(want.queue_count));
        end
      end
      if (start && !busy) replies_due.push_back(serve_queue_op(in_item));
    end
    replies_owed <= replies_due.size();
  end

endmodule

// ===== test/tb_sorted_priority_queue_top.sv =====
// Testbench top for the sorted priority queue: clock, reset and item stimulus.
// Depends on spq_pkg, sorted_priority_queue_top and spq_order_checker.
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_strobe;
  out_item_t   out_item;
  int          replies_owed;
  int          fail_count;
  int unsigned cycle_count = 0;

  sorted_priority_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  spq_order_checker order_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_strobe   (out_strobe),
    .out_item     (out_item),
    .replies_owed (replies_owed),
    .fail_count   (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t mk_item(input logic mode, input logic [31:0] data,
                                       input logic [15:0] prio);
    in_item_t it;
    it.mode        = mode;
    it.data_in     = data;
    it.priority_in = prio;
    return it;
  endfunction

  function automatic in_item_t pick_item(input int ins_pct, input bit narrow);
    logic mode;
    logic [15:0] prio;
    mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
    // narrow priorities pile up ties so arrival order gets exercised
    prio = narrow ? 16'(int'($urandom_range(0, 4)) - 2) : 16'($urandom);
    return mk_item(mode, $urandom, prio);
  endfunction

  // Idle with junk on the bus for the given gap, then hold the item until taken.
  task automatic offer_item(input in_item_t it, input int gap);
    if (gap > 0) begin
      start   <= 1'b0;
      in_item <= $bits(in_item_t)'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] fill_data [16];
    logic [15:0] fill_prio [16];
    int          sent;
    int          burst;
    int          ins_pct;
    int          gap_max;
    bit          narrow;
    bit          drained;

    fill_data = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                  32'h1, 32'h2, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9, 32'hA};
    fill_prio = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                  16'h0000, 16'h0000, 16'h5555, 16'hAAAA,
                  16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
                  16'h0001, 16'h0001, 16'h7FFF, 16'h0000};
    sent    = 0;
    drained = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty remove, fill to capacity with extremes and ties, overflow, drain a few
    offer_item(mk_item(MODE_REMOVE, 32'hDEAD_BEEF, 16'h1234), 2);
    for (int k = 0; k < 16; k++)
      offer_item(mk_item(MODE_INSERT, fill_data[k], fill_prio[k]), $urandom_range(0, 13));
    offer_item(mk_item(MODE_INSERT, 32'h1234_5678, 16'h0000), $urandom_range(0, 13));
    for (int k = 0; k < 4; k++)
      offer_item(mk_item(MODE_REMOVE, $urandom, 16'($urandom)), $urandom_range(0, 13));
    sent = 22;

    // bursts lean toward filling, draining or churning the queue
    while (sent < ITEM_TARGET) begin
      burst = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       ins_pct = 15;
        1:       ins_pct = 50;
        default: ins_pct = 85;
      endcase
      narrow  = 1'($urandom_range(0, 1));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      for (int k = 0; k < burst && sent < ITEM_TARGET; k++) begin
        offer_item(pick_item(ins_pct, narrow), $urandom_range(0, gap_max));
        sent++;
      end
      if (!drained && sent >= ITEM_TARGET / 2) begin
        // hold off until every owed result is back
        start <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
        drained = 1'b1;
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sorted_priority_queue_top.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
test/spq_order_checker.sv
test/tb_sorted_priority_queue_top.sv
